// ----- hw/rtl/pva_pkg.sv -----
// Shared types, constants and codes for the polyphonic voice allocator.
// No dependencies; pva_oldest, pva_alloc, the top level and the checker import it.
package pva_pkg;

    localparam int VOICES   = 8;
    localparam int AGE_BITS = 32;
    localparam int VIDX_W   = $clog2(VOICES);

    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [VIDX_W-1:0]   vidx_t;
    typedef logic [VOICES-1:0]   vmask_t;
    typedef logic [6:0]          note_t;

    typedef enum logic [1:0] {
        FUNC_NOTE_ON     = 2'd0,
        FUNC_NOTE_OFF    = 2'd1,
        FUNC_RELEASE_ALL = 2'd2,
        FUNC_REAP        = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_STARTED  = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_FREED    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PICK_SAME    = 2'd0,
        PICK_FREE    = 2'd1,
        PICK_RELEASE = 2'd2,
        PICK_STOLEN  = 2'd3
    } pick_t;

    typedef struct packed {
        logic [1:0] func;
        note_t      note;
        logic [6:0] velocity;
        logic [7:0] silent_mask;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] voice;
        logic [1:0] pick_class;
        note_t      out_note;
        logic [6:0] out_velocity;
        logic [7:0] voice_mask;
    } result_t;

endpackage

// ----- hw/rtl/pva_cmd_if.sv -----
// Request channel of the voice allocator: valid, ready and the request fields.
// Depends on nothing.
interface pva_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [7:0] silent_mask;

    modport source (output valid, func, note, velocity, silent_mask, input ready);
    modport sink   (input valid, func, note, velocity, silent_mask, output ready);
endinterface

// ----- hw/rtl/pva_res_if.sv -----
// Result channel of the voice allocator: valid, ready and the result fields.
// Depends on nothing.
interface pva_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] voice;
    logic [1:0] pick_class;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic [7:0] voice_mask;

    modport source (output valid, kind, voice, pick_class, out_note, out_velocity,
                    voice_mask, input ready);
    modport sink   (input valid, kind, voice, pick_class, out_note, out_velocity,
                    voice_mask, output ready);
endinterface

// ----- hw/rtl/pva_oldest.sv -----
// Finds the oldest voice in a candidate set by a full pairwise age compare.
// Depends on pva_pkg.
module pva_oldest (
    input  pva_pkg::vmask_t member,
    input  pva_pkg::age_t   ages [pva_pkg::VOICES],
    output logic            found,
    output pva_pkg::vidx_t  idx
);
    import pva_pkg::*;

    vmask_t win;

    always_comb
    begin
        win = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            win[v] = member[v];
            for (int u = 0; u < VOICES; u++)
            begin
                if (u < v && member[u] && !(ages[v] < ages[u]))
                begin
                    win[v] = 1'b0;
                end
                else if (u > v && member[u] && (ages[u] < ages[v]))
                begin
                    win[v] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        idx = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (win[v])
            begin
                idx = idx | vidx_t'(v);
            end
        end
    end

    assign found = |member;

endmodule

// ----- hw/rtl/pva_alloc.sv -----
// Voice state registers and the combinational execution of one request.
// Depends on pva_pkg and pva_oldest.
module pva_alloc (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  pva_pkg::cmd_t    cmd,
    output pva_pkg::result_t res
);
    import pva_pkg::*;

    vmask_t assigned_reg, assigned_next;
    vmask_t gated_reg, gated_next;
    note_t  held_note_reg [VOICES];
    note_t  held_note_next [VOICES];
    age_t   alloc_age_reg [VOICES];
    age_t   alloc_age_next [VOICES];
    age_t   age_counter_reg, age_counter_next;

    vmask_t same_hit, free_set, rel_set, gate_set, mask;
    logic   same_found, free_found, rel_found, gate_found;
    vidx_t  same_idx, free_idx, rel_idx, gate_idx, pick;
    logic [1:0]          cls;
    logic [VOICES+7:0]   silent_ext;
    logic [VOICES+7:0]   mask_ext;
    logic [31:0]         pick_ext;

    assign free_set = ~assigned_reg;
    assign rel_set  = assigned_reg & ~gated_reg;
    assign gate_set = assigned_reg & gated_reg;

    always_comb
    begin
        same_hit = '0;
        for (int v = 0; v < VOICES; v++)
        begin
            same_hit[v] = assigned_reg[v] && (held_note_reg[v] == cmd.note);
        end
    end

    always_comb
    begin
        same_idx = '0;
        for (int v = VOICES - 1; v >= 0; v--)
        begin
            if (same_hit[v])
            begin
                same_idx = vidx_t'(v);
            end
        end
    end

    assign same_found = |same_hit;

    pva_oldest u_free (.member(free_set), .ages(alloc_age_reg), .found(free_found),
                       .idx(free_idx));
    pva_oldest u_rel  (.member(rel_set),  .ages(alloc_age_reg), .found(rel_found),
                       .idx(rel_idx));
    pva_oldest u_gate (.member(gate_set), .ages(alloc_age_reg), .found(gate_found),
                       .idx(gate_idx));

    always_comb
    begin
        priority if (same_found)
        begin
            pick = same_idx;
            cls  = PICK_SAME;
        end
        else if (free_found)
        begin
            pick = free_idx;
            cls  = PICK_FREE;
        end
        else if (rel_found)
        begin
            pick = rel_idx;
            cls  = PICK_RELEASE;
        end
        else if (gate_found)
        begin
            pick = gate_idx;
            cls  = PICK_STOLEN;
        end
        else
        begin
            pick = '0;
            cls  = PICK_STOLEN;
        end
    end

    assign silent_ext = (VOICES + 8)'(cmd.silent_mask);
    assign pick_ext   = 32'(pick);

    always_comb
    begin
        assigned_next    = assigned_reg;
        gated_next       = gated_reg;
        held_note_next   = held_note_reg;
        alloc_age_next   = alloc_age_reg;
        age_counter_next = age_counter_reg;
        mask             = '0;
        res              = '0;
        unique case (func_t'(cmd.func))
            FUNC_NOTE_ON:
            begin
                assigned_next[pick]  = 1'b1;
                gated_next[pick]     = 1'b1;
                held_note_next[pick] = cmd.note;
                age_counter_next     = age_counter_reg + age_t'(1);
                alloc_age_next[pick] = age_counter_next;
                res.kind             = KIND_STARTED;
                res.voice            = pick_ext[2:0];
                res.pick_class       = cls;
                res.out_note         = cmd.note;
                res.out_velocity     = cmd.velocity;
            end
            FUNC_NOTE_OFF, FUNC_RELEASE_ALL:
            begin
                if (func_t'(cmd.func) == FUNC_RELEASE_ALL)
                begin
                    mask = assigned_reg;
                end
                else
                begin
                    mask = same_hit & gated_reg;
                end
                gated_next = gated_reg & ~mask;
                res.kind   = KIND_RELEASED;
            end
            FUNC_REAP:
            begin
                mask          = rel_set & silent_ext[VOICES-1:0];
                assigned_next = assigned_reg & ~mask;
                res.kind      = KIND_FREED;
            end
            default:
            begin
                res.kind = KIND_FREED;
            end
        endcase
        mask_ext       = (VOICES + 8)'(mask);
        res.voice_mask = mask_ext[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assigned_reg    <= '0;
            gated_reg       <= '0;
            age_counter_reg <= '0;
            for (int v = 0; v < VOICES; v++)
            begin
                held_note_reg[v] <= '0;
                alloc_age_reg[v] <= '0;
            end
        end
        else if (fire)
        begin
            assigned_reg    <= assigned_next;
            gated_reg       <= gated_next;
            age_counter_reg <= age_counter_next;
            held_note_reg   <= held_note_next;
            alloc_age_reg   <= alloc_age_next;
        end
    end

endmodule

// ----- hw/rtl/polyphonic_voice_allocator_unit.sv -----
// Top level of the polyphonic voice allocator: request register, voice core, result register.
// A request waits in the request register; its result then goes to the result register.
// Throughput: one request per cycle while the result side is not stalled.
// A stalled result register holds the request register, which then lowers ready.
// Reset (rst_n low, asynchronous) frees all voices, clears ages, counter and both valid flags.
// Depends on pva_pkg, pva_cmd_if, pva_res_if and pva_alloc.
module polyphonic_voice_allocator_unit (
    input logic     clk,
    input logic     rst_n,
    pva_cmd_if.sink cmd,
    pva_res_if.source res
);
    import pva_pkg::*;

    logic    in_valid_reg, out_valid_reg, fire;
    cmd_t    cmd_reg;
    result_t res_reg, res_next;

    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || fire;

    pva_alloc u_alloc (.clk(clk), .rst_n(rst_n), .fire(fire), .cmd(cmd_reg), .res(res_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_reg <= '{func: cmd.func, note: cmd.note, velocity: cmd.velocity,
                         silent_mask: cmd.silent_mask};
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = res_reg.kind;
    assign res.voice        = res_reg.voice;
    assign res.pick_class   = res_reg.pick_class;
    assign res.out_note     = res_reg.out_note;
    assign res.out_velocity = res_reg.out_velocity;
    assign res.voice_mask   = res_reg.voice_mask;

endmodule

// ----- hw/rtl/pva_checker.sv -----
// Port-level checks on the voice allocator results, bound to the top level.
// Depends on pva_pkg and polyphonic_voice_allocator_unit.
module pva_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] kind,
    input logic [2:0] voice,
    input logic [1:0] pick_class,
    input logic [6:0] out_note,
    input logic [6:0] out_velocity,
    input logic [7:0] voice_mask
);
    import pva_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(voice_mask)
            && $stable(voice))
        else $error("A stalled result changed.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (kind == KIND_STARTED || kind == KIND_RELEASED || kind == KIND_FREED))
        else $error("Result kind is not a defined code.");

    a_start_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_STARTED |-> voice_mask == 8'd0)
        else $error("A voice start carries a voice mask.");

    a_mask_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_STARTED |-> voice == 3'd0 && pick_class == 2'd0
            && out_note == 7'd0 && out_velocity == 7'd0)
        else $error("A release or free result carries voice start fields.");

endmodule

bind polyphonic_voice_allocator_unit pva_checker u_pva_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .kind(res.kind),
    .voice(res.voice),
    .pick_class(res.pick_class),
    .out_note(res.out_note),
    .out_velocity(res.out_velocity),
    .voice_mask(res.voice_mask)
);
